FILE: sv/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg - shared constants and types for the Bezier curve evaluator
// Widths of the fixed-point datapath, register indexes and the bundles that
// travel down the weight pipeline and the accumulate chain.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int MAX_POINTS     = 4;
    localparam int COORD_BITS     = 16;
    localparam int NUM_LANES      = 3;
    localparam int PT_BITS        = 48;
    localparam int NUM_POINT_REGS = 4;
    localparam int CNT_BITS       = 3;
    localparam int FUNC_BITS      = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int IDX_BITS       = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    // Q.16 parameter and power values, 65536 is one
    localparam int T_BITS    = 17;
    localparam int FRAC_BITS = 16;
    localparam int HALF_Q    = 32768;

    // third forward difference grows three bits
    localparam int DIFF_BITS  = COORD_BITS + 3;
    localparam int PROD_BITS  = 2 * T_BITS;
    localparam int BINOM_BITS = MAX_POINTS - 1;
    localparam int FACT_MAX   = (MAX_POINTS >= 4) ?
                                (MAX_POINTS - 1) * (MAX_POINTS - 2) * (MAX_POINTS - 3) :
                                MAX_POINTS - 1;
    localparam int FACT_BITS  = $clog2(FACT_MAX + 1);
    localparam int MPROD_BITS = DIFF_BITS + T_BITS + 1;
    localparam int ACC_BITS   = MPROD_BITS + $clog2(MAX_POINTS);

    localparam int SCALED_BITS = ACC_BITS + FACT_BITS + 1;
    localparam int RND_BITS    = SCALED_BITS - FRAC_BITS;
    localparam int OUT_BITS    = 24;
    localparam int EXT_BITS    = (RND_BITS > OUT_BITS) ? RND_BITS : OUT_BITS + 1;
    localparam int OUT_MAX     = 8388607;
    localparam int OUT_MIN     = -8388608;

    localparam logic [T_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_POINT_A     = 3'd1,
        REG_POINT_B     = 3'd2,
        REG_POINT_C     = 3'd3,
        REG_POINT_D     = 3'd4
    } t_cfg_reg;

    // item entering the power pipeline
    typedef struct packed {
        logic                                              err;
        logic [IDX_BITS-1:0]                               m;
        logic [FACT_BITS-1:0]                              factor;
        logic [T_BITS-1:0]                                 t;
        logic [T_BITS-1:0]                                 s;
        logic [MAX_POINTS-1:0][T_BITS-1:0]                 tp;
        logic [MAX_POINTS-1:0][T_BITS-1:0]                 sp;
        logic [MAX_POINTS-1:0][NUM_LANES-1:0][DIFF_BITS-1:0] d;
    } t_front;

    // item travelling down the accumulate chain; slot 0 is consumed per cell
    typedef struct packed {
        logic                                              err;
        logic [FACT_BITS-1:0]                              factor;
        logic [NUM_LANES-1:0][ACC_BITS-1:0]                acc;
        logic [MAX_POINTS-1:0][T_BITS-1:0]                 w;
        logic [MAX_POINTS-1:0][NUM_LANES-1:0][DIFF_BITS-1:0] d;
    } t_row;

endpackage

FILE: sv/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// bezier_curve_evaluator - 3D Bezier point and derivative evaluation
// Pipeline: an accepted request passes through the input register,
//   MAX_POINTS-1 power stages, product, weight, MAX_POINTS accumulate
//   cells and the output register.
// Throughput: one request per cycle; the input stalls only while the output
//   skid register is occupied.
// Reset (synchronous, active low): pipeline empties, point count returns to
//   four and all control points to zero.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bce_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [bce_pkg::PT_BITS-1:0]         i_cfg_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bce_pkg::FUNC_BITS-1:0]       i_func,
    input  logic [bce_pkg::T_BITS-1:0]          i_t_param,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bce_pkg::OUT_BITS-1:0] o_out_x,
    output logic signed [bce_pkg::OUT_BITS-1:0] o_out_y,
    output logic signed [bce_pkg::OUT_BITS-1:0] o_out_z,
    output logic                                o_order_error
);

    typedef struct packed {
        logic                                                   err;
        logic [bce_pkg::NUM_LANES-1:0][bce_pkg::OUT_BITS-1:0]   v;
    } t_result;

    localparam logic signed [bce_pkg::EXT_BITS-1:0] EXT_MAX =
        bce_pkg::EXT_BITS'(bce_pkg::OUT_MAX);
    localparam logic signed [bce_pkg::EXT_BITS-1:0] EXT_MIN =
        bce_pkg::EXT_BITS'(bce_pkg::OUT_MIN);

    // Coordinate lane l of a packed point, sign-extended to difference width.
    // Lane bits beyond the 48-bit register read as zero.
    function automatic logic signed [bce_pkg::DIFF_BITS-1:0] lane_of(
        logic [bce_pkg::PT_BITS-1:0] pt,
        int                          l
    );
        logic [bce_pkg::COORD_BITS-1:0] v;
        for (int b = 0; b < bce_pkg::COORD_BITS; b++) begin
            v[b] = (l * bce_pkg::COORD_BITS + b < bce_pkg::PT_BITS) ?
                   pt[l * bce_pkg::COORD_BITS + b] : 1'b0;
        end
        return bce_pkg::DIFF_BITS'($signed(v));
    endfunction

    // Falling factorial (n-1)(n-2)...(n-k); derivative order is at most three.
    function automatic logic [bce_pkg::FACT_BITS-1:0] falling(
        logic [bce_pkg::CNT_BITS-1:0]  n,
        logic [bce_pkg::FUNC_BITS-1:0] k
    );
        logic [bce_pkg::FACT_BITS-1:0] f;
        f = bce_pkg::FACT_BITS'(1);
        for (int j = 0; j < 3; j++) begin
            if (j < k) begin
                f = bce_pkg::FACT_BITS'(f * bce_pkg::FACT_BITS'(
                        n - bce_pkg::CNT_BITS'(1) - bce_pkg::CNT_BITS'(j)));
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The port never back-pressures; writes to
    // unknown indexes fall through untouched.
    // ------------------------------------------------------------------
    logic [bce_pkg::CNT_BITS-1:0] r_point_count;
    logic [bce_pkg::PT_BITS-1:0]  r_pts [bce_pkg::MAX_POINTS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= bce_pkg::CNT_BITS'(4);
            for (int p = 0; p < bce_pkg::MAX_POINTS; p++) begin
                r_pts[p] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == bce_pkg::REG_POINT_COUNT) begin
                r_point_count <= i_cfg_data[bce_pkg::CNT_BITS-1:0];
            end
            for (int p = 0; p < bce_pkg::MAX_POINTS; p++) begin
                if (p < bce_pkg::NUM_POINT_REGS &&
                    i_cfg_index == bce_pkg::CFG_IDX_BITS'(bce_pkg::REG_POINT_A)
                                 + bce_pkg::CFG_IDX_BITS'(p)) begin
                    r_pts[p] <= i_cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves together unless the skid holds
    // a result, so a request is still taken while the output register is
    // waiting on the consumer.
    // ------------------------------------------------------------------
    logic    w_en;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // ------------------------------------------------------------------
    // Input stage: clamp count and t, flag bad orders, pick the degree and
    // scale, and take the k-th forward differences of the points. The
    // differences past index m are junk but meet zero weights downstream.
    // ------------------------------------------------------------------
    bce_pkg::t_front n_s0;
    bce_pkg::t_front r_s0;
    logic            r_s0_valid;

    always_comb begin
        logic [bce_pkg::CNT_BITS-1:0]  n;
        logic [bce_pkg::CNT_BITS-1:0]  kx;
        logic [bce_pkg::T_BITS-1:0]    t;
        logic signed [bce_pkg::DIFF_BITS-1:0] lv [bce_pkg::MAX_POINTS][bce_pkg::NUM_LANES];

        if (r_point_count < bce_pkg::CNT_BITS'(2)) begin
            n = bce_pkg::CNT_BITS'(2);
        end else if (r_point_count > bce_pkg::CNT_BITS'(bce_pkg::MAX_POINTS)) begin
            n = bce_pkg::CNT_BITS'(bce_pkg::MAX_POINTS);
        end else begin
            n = r_point_count;
        end
        kx = bce_pkg::CNT_BITS'(i_func);
        t  = (i_t_param > bce_pkg::ONE_Q) ? bce_pkg::ONE_Q : i_t_param;

        for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
            for (int c = 0; c < bce_pkg::NUM_LANES; c++) begin
                lv[i][c] = lane_of(r_pts[i], c);
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (j < i_func) begin
                for (int i = 0; i < bce_pkg::MAX_POINTS - 1; i++) begin
                    for (int c = 0; c < bce_pkg::NUM_LANES; c++) begin
                        lv[i][c] = lv[i+1][c] - lv[i][c];
                    end
                end
            end
        end

        n_s0.err    = (kx >= n);
        n_s0.m      = bce_pkg::IDX_BITS'(n - bce_pkg::CNT_BITS'(1) - kx);
        n_s0.factor = falling(n, i_func);
        n_s0.t      = t;
        n_s0.s      = bce_pkg::ONE_Q - t;
        n_s0.tp     = '0;
        n_s0.sp     = '0;
        n_s0.tp[0]  = bce_pkg::ONE_Q;
        n_s0.sp[0]  = bce_pkg::ONE_Q;
        for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
            for (int c = 0; c < bce_pkg::NUM_LANES; c++) begin
                n_s0.d[i][c] = lv[i][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    // ------------------------------------------------------------------
    // Powers and Bernstein weights, then the accumulate chain: cell g adds
    // term g of the sum for all three lanes and passes the rest along.
    // ------------------------------------------------------------------
    bce_pkg::t_row w_cell_row   [bce_pkg::MAX_POINTS+1];
    logic          w_cell_valid [bce_pkg::MAX_POINTS+1];

    bce_weights u_weights (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_front (r_s0),
        .o_valid (w_cell_valid[0]),
        .o_row   (w_cell_row[0])
    );

    for (genvar g = 0; g < bce_pkg::MAX_POINTS; g++) begin : g_cell
        bce_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cell_valid[g]),
            .i_row   (w_cell_row[g]),
            .o_valid (w_cell_valid[g+1]),
            .o_row   (w_cell_row[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale by the falling factorial, round half up to coordinate scale,
    // saturate to 24 bits. Bad orders come out as zero with the flag set.
    // ------------------------------------------------------------------
    t_result n_res;

    always_comb begin
        logic signed [bce_pkg::SCALED_BITS-1:0] scaled;
        logic signed [bce_pkg::SCALED_BITS-1:0] rq;
        logic signed [bce_pkg::EXT_BITS-1:0]    ext;
        n_res.err = w_cell_row[bce_pkg::MAX_POINTS].err;
        for (int c = 0; c < bce_pkg::NUM_LANES; c++) begin
            scaled = bce_pkg::SCALED_BITS'($signed(w_cell_row[bce_pkg::MAX_POINTS].acc[c]))
                   * bce_pkg::SCALED_BITS'($signed({1'b0,
                                           w_cell_row[bce_pkg::MAX_POINTS].factor}));
            rq  = scaled + bce_pkg::SCALED_BITS'(bce_pkg::HALF_Q);
            ext = bce_pkg::EXT_BITS'($signed(rq[bce_pkg::SCALED_BITS-1:bce_pkg::FRAC_BITS]));
            if (w_cell_row[bce_pkg::MAX_POINTS].err) begin
                n_res.v[c] = '0;
            end else if (ext > EXT_MAX) begin
                n_res.v[c] = EXT_MAX[bce_pkg::OUT_BITS-1:0];
            end else if (ext < EXT_MIN) begin
                n_res.v[c] = EXT_MIN[bce_pkg::OUT_BITS-1:0];
            end else begin
                n_res.v[c] = ext[bce_pkg::OUT_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register plus one skid entry. A finished result lands in the
    // output register when it is free or being taken, otherwise in the
    // skid, which then freezes the pipeline until it drains.
    // ------------------------------------------------------------------
    logic    w_take;
    logic    n_out_valid;
    logic    n_skid_valid;
    logic    n_load_out;
    logic    n_load_skid;
    t_result n_out;

    assign w_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_load_out   = 1'b0;
        n_load_skid  = 1'b0;
        n_out        = n_res;
        priority if (r_skid_valid) begin
            if (w_take) begin
                n_load_out   = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_cell_valid[bce_pkg::MAX_POINTS]) begin
            if (!r_out_valid || w_take) begin
                n_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                n_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            r_out <= n_out;
        end
        if (n_load_skid) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = $signed(r_out.v[0]);
    assign o_out_y       = $signed(r_out.v[1]);
    assign o_out_z       = $signed(r_out.v[2]);
    assign o_order_error = r_out.err;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (o_out_valid && !r_skid_valid))
        else $error("skid entry did not move into the output register");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order_error) |->
        (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("order error result carries nonzero coordinates");
`endif

endmodule

FILE: sv/bce_cell.sv
// ----------------------------------------------------------------------------
// bce_cell - one multiply-accumulate cell of the Bernstein sum chain
// Adds the product of the head difference and head weight to the running
// sums, then hands the remaining terms on, shifted down by one slot.
// ----------------------------------------------------------------------------
module bce_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  bce_pkg::t_row i_row,
    output logic          o_valid,
    output bce_pkg::t_row o_row
);

    bce_pkg::t_row n_row;
    bce_pkg::t_row r_row;
    logic          r_valid;

    always_comb begin
        logic signed [bce_pkg::MPROD_BITS-1:0] term;
        n_row = i_row;
        for (int c = 0; c < bce_pkg::NUM_LANES; c++) begin
            term = bce_pkg::MPROD_BITS'($signed(i_row.d[0][c]))
                 * bce_pkg::MPROD_BITS'($signed({1'b0, i_row.w[0]}));
            n_row.acc[c] = i_row.acc[c] + bce_pkg::ACC_BITS'(term);
        end
        for (int i = 0; i < bce_pkg::MAX_POINTS - 1; i++) begin
            n_row.d[i] = i_row.d[i+1];
            n_row.w[i] = i_row.w[i+1];
        end
        n_row.d[bce_pkg::MAX_POINTS-1] = '0;
        n_row.w[bce_pkg::MAX_POINTS-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;

endmodule

FILE: sv/bce_weights.sv
// ----------------------------------------------------------------------------
// bce_weights - power pipeline and Bernstein weight generation
// One stage per power of t and (1 - t), then the cross products selected by
// the degree, then binomial scaling and rounding into Q.16 weights.
// ----------------------------------------------------------------------------
module bce_weights (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  bce_pkg::t_front i_front,
    output logic            o_valid,
    output bce_pkg::t_row   o_row
);

    localparam int POW_STAGES = bce_pkg::MAX_POINTS - 1;
    localparam int WQ_BITS    = bce_pkg::BINOM_BITS + bce_pkg::PROD_BITS;

    typedef struct packed {
        logic                                                   err;
        logic [bce_pkg::IDX_BITS-1:0]                           m;
        logic [bce_pkg::FACT_BITS-1:0]                          factor;
        logic [bce_pkg::MAX_POINTS-1:0][bce_pkg::PROD_BITS-1:0] p;
        logic [bce_pkg::MAX_POINTS-1:0][bce_pkg::NUM_LANES-1:0]
              [bce_pkg::DIFF_BITS-1:0]                          d;
    } t_prod;

    // (p * t + half) >> 16
    function automatic logic [bce_pkg::T_BITS-1:0] pow_step(
        logic [bce_pkg::T_BITS-1:0] p,
        logic [bce_pkg::T_BITS-1:0] t
    );
        logic [bce_pkg::PROD_BITS-1:0] q;
        q = bce_pkg::PROD_BITS'(p) * bce_pkg::PROD_BITS'(t)
          + bce_pkg::PROD_BITS'(bce_pkg::HALF_Q);
        return q[bce_pkg::FRAC_BITS +: bce_pkg::T_BITS];
    endfunction

    // Pascal row m, built by additions
    function automatic logic [bce_pkg::BINOM_BITS-1:0] binom(
        logic [bce_pkg::IDX_BITS-1:0] m,
        int                           i
    );
        logic [bce_pkg::MAX_POINTS-1:0][bce_pkg::BINOM_BITS-1:0] c;
        c    = '0;
        c[0] = bce_pkg::BINOM_BITS'(1);
        for (int r = 1; r < bce_pkg::MAX_POINTS; r++) begin
            if (r <= m) begin
                for (int j = bce_pkg::MAX_POINTS - 1; j >= 1; j--) begin
                    c[j] = c[j] + c[j-1];
                end
            end
        end
        return c[i];
    endfunction

    bce_pkg::t_front w_stg       [POW_STAGES+1];
    logic            w_stg_valid [POW_STAGES+1];

    assign w_stg[0]       = i_front;
    assign w_stg_valid[0] = i_valid;

    // stage g produces t^(g+1) and s^(g+1)
    for (genvar g = 0; g < POW_STAGES; g++) begin : g_pow
        bce_pkg::t_front n_pw;
        bce_pkg::t_front r_pw;
        logic            r_pw_valid;

        always_comb begin
            n_pw         = w_stg[g];
            n_pw.tp[g+1] = pow_step(w_stg[g].tp[g], w_stg[g].t);
            n_pw.sp[g+1] = pow_step(w_stg[g].sp[g], w_stg[g].s);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pw_valid <= 1'b0;
            end else if (i_en) begin
                r_pw_valid <= w_stg_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pw <= n_pw;
            end
        end

        assign w_stg[g+1]       = r_pw;
        assign w_stg_valid[g+1] = r_pw_valid;
    end

    // cross products t^i * s^(m-i); zero where i is past the degree
    t_prod n_prod;
    t_prod r_prod;
    logic  r_prod_valid;

    always_comb begin
        logic [bce_pkg::T_BITS-1:0] sel;
        n_prod.err    = w_stg[POW_STAGES].err;
        n_prod.m      = w_stg[POW_STAGES].m;
        n_prod.factor = w_stg[POW_STAGES].factor;
        n_prod.d      = w_stg[POW_STAGES].d;
        for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
            sel = '0;
            for (int j = 0; j < bce_pkg::MAX_POINTS; j++) begin
                if (i + j == w_stg[POW_STAGES].m) begin
                    sel = w_stg[POW_STAGES].sp[j];
                end
            end
            n_prod.p[i] = bce_pkg::PROD_BITS'(w_stg[POW_STAGES].tp[i])
                        * bce_pkg::PROD_BITS'(sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (i_en) begin
            r_prod_valid <= w_stg_valid[POW_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // weights w_i = (C(m,i) * p_i + half) >> 16
    bce_pkg::t_row n_row;
    bce_pkg::t_row r_row;
    logic          r_row_valid;

    always_comb begin
        logic [WQ_BITS-1:0] wq;
        n_row.err    = r_prod.err;
        n_row.factor = r_prod.factor;
        n_row.acc    = '0;
        n_row.d      = r_prod.d;
        for (int i = 0; i < bce_pkg::MAX_POINTS; i++) begin
            wq = WQ_BITS'(binom(r_prod.m, i)) * WQ_BITS'(r_prod.p[i])
               + WQ_BITS'(bce_pkg::HALF_Q);
            n_row.w[i] = wq[bce_pkg::FRAC_BITS +: bce_pkg::T_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= 1'b0;
        end else if (i_en) begin
            r_row_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    assign o_valid = r_row_valid;
    assign o_row   = r_row;

endmodule

FILE: tb/tb_bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// tb_bezier_curve_evaluator - self-checking bench for the Bezier evaluator
// Writes the point count and the control points between traffic phases,
// streams (func, t) requests with random gaps and output stalls, and checks
// every result against a fixed-point Bernstein-sum model kept in the bench or a value given in the plan.
// ----------------------------------------------------------------------------
module tb_bezier_curve_evaluator;

    import bce_pkg::*;

    // derivative order carried by i_func
    typedef enum logic [FUNC_BITS-1:0] {
        FN_POINT = 2'd0,
        FN_D1    = 2'd1,
        FN_D2    = 2'd2,
        FN_D3    = 2'd3
    } curve_func_e;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        logic                       err;
    } curve_sample_t;

    // one line of the directed plan: a register write or a request
    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [PT_BITS-1:0]       reg_data;
        logic [FUNC_BITS-1:0]     func;
        logic [T_BITS-1:0]        t;
        bit                       typed;
        curve_sample_t            want;
    } plan_row_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_FIRST = CFG_IDX_BITS'(REG_POINT_D + 1);
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_LAST  = '1;

    localparam int IDLE_PCT        = 34;
    localparam int PIPE_DEPTH      = 2 * MAX_POINTS + 3;
    localparam int QUIET_LIMIT     = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int CALM_PHASE      = 5;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index = '0;
    logic [PT_BITS-1:0]          i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic [FUNC_BITS-1:0]        i_func      = '0;
    logic [T_BITS-1:0]           i_t_param   = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [OUT_BITS-1:0]  o_out_x;
    logic signed [OUT_BITS-1:0]  o_out_y;
    logic signed [OUT_BITS-1:0]  o_out_z;
    logic                        o_order_error;

    // bench copy of the curve registers
    logic [CNT_BITS-1:0]  cur_count;
    logic [PT_BITS-1:0]   ctrl_pts [MAX_POINTS];

    curve_sample_t awaited_samples[$];
    plan_row_t     plan[$];

    bit calm = 1'b0;    // no gaps on either side while set
    int n_requests   = 0;
    int n_directed   = 0;
    int n_checked    = 0;
    int n_order_err  = 0;
    int n_mismatch   = 0;
    int n_settings   = 0;
    int quiet_cycles = 0;

    int unsigned phase_counts [NUM_PHASES] = '{4, 2, 3, 0, 7, 4, 1, 3};

    bezier_curve_evaluator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_t_param     (i_t_param),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_order_error (o_order_error)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Curve model. Order k runs on the k-th forward differences of the points,
    // weighted by degree n-1-k Bernstein terms in Q.16 and scaled by the
    // falling factorial. Every product stays well inside 64 bits.
    // ------------------------------------------------------------------------
    function automatic curve_sample_t eval_curve(logic [FUNC_BITS-1:0] fn,
                                                 logic [T_BITS-1:0] t_raw);
        curve_sample_t res;
        longint diff [MAX_POINTS][NUM_LANES];
        longint tpow [MAX_POINTS];
        longint spow [MAX_POINTS];
        longint lane_out [NUM_LANES];
        longint t, s, factor, acc, w, binom, v;
        int n, k, m;
        res = '0;
        k = int'(fn);
        n = int'(cur_count);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        // parameter above one is clamped to one
        t = (t_raw > ONE_Q) ? longint'(ONE_Q) : longint'(t_raw);
        s = longint'(ONE_Q) - t;
        if (k >= n) begin
            res.err = 1'b1;
            return res;
        end
        for (int i = 0; i < n; i++)
            for (int l = 0; l < NUM_LANES; l++)
                diff[i][l] = longint'($signed(ctrl_pts[i][l*COORD_BITS +: COORD_BITS]));
        for (int j = 0; j < k; j++)
            for (int i = 0; i + 1 < n - j; i++)
                for (int l = 0; l < NUM_LANES; l++)
                    diff[i][l] = diff[i+1][l] - diff[i][l];
        m = n - 1 - k;
        tpow[0] = longint'(ONE_Q);
        spow[0] = longint'(ONE_Q);
        for (int j = 1; j <= m; j++) begin
            tpow[j] = (tpow[j-1] * t + HALF_Q) >>> FRAC_BITS;
            spow[j] = (spow[j-1] * s + HALF_Q) >>> FRAC_BITS;
        end
        factor = 1;
        for (int j = 0; j < k; j++)
            factor *= longint'(n - 1 - j);
        for (int l = 0; l < NUM_LANES; l++) begin
            acc = 0;
            for (int i = 0; i <= m; i++) begin
                binom = 1;
                for (int j = 0; j < i; j++)
                    binom = binom * (m - j) / (j + 1);
                w = (binom * tpow[i] * spow[m-i] + HALF_Q) >>> FRAC_BITS;
                acc += diff[i][l] * w;
            end
            // round half up, then clip to the output range
            v = (acc * factor + HALF_Q) >>> FRAC_BITS;
            if (v > OUT_MAX) v = OUT_MAX;
            if (v < OUT_MIN) v = OUT_MIN;
            lane_out[l] = v;
        end
        res.x = lane_out[0][OUT_BITS-1:0];
        res.y = lane_out[1][OUT_BITS-1:0];
        res.z = lane_out[2][OUT_BITS-1:0];
        return res;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PT_BITS-1:0] data);
        case (idx)
            REG_POINT_COUNT: begin
                cur_count = data[CNT_BITS-1:0];
            end
            REG_POINT_A, REG_POINT_B, REG_POINT_C, REG_POINT_D: begin
                ctrl_pts[idx - REG_POINT_A] = data;
            end
            default: ;  // unmapped index, dropped
        endcase
    endfunction

    function automatic logic [PT_BITS-1:0] pack_point(int x, int y, int z);
        return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [T_BITS-1:0] pick_t_param();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_Q;
            2:       return T_BITS'($urandom_range(131071, 65537));
            3:       return T_BITS'($urandom_range(15));
            4:       return ONE_Q - T_BITS'($urandom_range(15));
            default: return T_BITS'($urandom_range(65536));
        endcase
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [PT_BITS-1:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic plan_row_t req_row(curve_func_e fn, int t);
        plan_row_t r;
        r = '{default: '0};
        r.func = fn;
        r.t    = t[T_BITS-1:0];
        return r;
    endfunction

    // request whose answer is plain to see: a zero curve, an end point,
    // a straight-line slope or an order error
    function automatic plan_row_t known_row(curve_func_e fn, int t, int x, int y, int z, bit err);
        plan_row_t r;
        r = req_row(fn, t);
        r.typed  = 1'b1;
        r.want.x = x[OUT_BITS-1:0];
        r.want.y = y[OUT_BITS-1:0];
        r.want.z = z[OUT_BITS-1:0];
        r.want.err = err;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Handshake tasks. Every drive happens right after a rising edge, so the
    // block samples it at the following edge; valid is never dropped and
    // raised in the same step.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PT_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        if (idx == REG_POINT_COUNT) n_settings++;
    endtask

    task automatic send_request(logic [FUNC_BITS-1:0] fn, logic [T_BITS-1:0] t,
                                bit typed, curve_sample_t want);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_t_param  <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // accepted at this edge; registers are static while traffic runs
        awaited_samples.push_back(typed ? want : eval_curve(fn, t));
        n_requests++;
    endtask

    // sender holds off until every outstanding result is back; the block is
    // then idle and safe for register writes
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (awaited_samples.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic compare_field(string field, logic signed [OUT_BITS-1:0] want,
                                 logic signed [OUT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            n_mismatch++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, and every accepted result is checked
    // against the oldest pending expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        curve_sample_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none, got x=%0d y=%0d z=%0d err=%0b",
                         $time, o_out_x, o_out_y, o_out_z, o_order_error);
                n_mismatch++;
            end else begin
                want = awaited_samples.pop_front();
                compare_field("out_x", want.x, o_out_x);
                compare_field("out_y", want.y, o_out_y);
                compare_field("out_z", want.z, o_out_z);
                compare_field("order_error", OUT_BITS'(want.err), OUT_BITS'(o_order_error));
                n_checked++;
                if (want.err) n_order_err++;
            end
        end
    end

    // watchdog: too long without any handshake on any channel ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, awaited_samples.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit in_busy;
        bit cfg_busy;
        cur_count = CNT_BITS'(MAX_POINTS);
        foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
        in_busy  = 1'b0;
        cfg_busy = 1'b0;

        // reset values: four points, all at the origin
        plan.push_back(known_row(FN_POINT, 0,     0, 0, 0, 1'b0));
        plan.push_back(known_row(FN_D3,    65536, 0, 0, 0, 1'b0));
        plan.push_back(known_row(FN_D1,    32768, 0, 0, 0, 1'b0));
        // points at the coordinate extremes
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd4));
        plan.push_back(cfg_row(REG_POINT_A, pack_point(32767, -32768, 1)));
        plan.push_back(cfg_row(REG_POINT_B, pack_point(-1, 0, 32767)));
        plan.push_back(cfg_row(REG_POINT_C, pack_point(12345, -23456, -32768)));
        plan.push_back(cfg_row(REG_POINT_D, pack_point(-32768, 32767, -1)));
        // end points land exactly on the first and last control point
        plan.push_back(known_row(FN_POINT, 0,      32767, -32768, 1, 1'b0));
        plan.push_back(known_row(FN_POINT, 65536, -32768,  32767, -1, 1'b0));
        // parameter above one clamps to one
        plan.push_back(known_row(FN_POINT, 131071, -32768, 32767, -1, 1'b0));
        plan.push_back(req_row(FN_D1, 32768));
        plan.push_back(req_row(FN_D2, 1));
        plan.push_back(req_row(FN_D3, 65535));
        plan.push_back(req_row(FN_D1, 65536));
        // line: slope is B - A, second and third order are errors
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd2));
        plan.push_back(known_row(FN_POINT, 65536, -1, 0, 32767, 1'b0));
        plan.push_back(known_row(FN_D1, 40000, -32768, 32768, 32766, 1'b0));
        plan.push_back(known_row(FN_D2, 0,     0, 0, 0, 1'b1));
        plan.push_back(known_row(FN_D3, 65536, 0, 0, 0, 1'b1));
        // count below two behaves as two
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd0));
        plan.push_back(known_row(FN_D2, 100, 0, 0, 0, 1'b1));
        plan.push_back(known_row(FN_D1, 0, -32768, 32768, 32766, 1'b0));
        // count above the maximum behaves as four
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd7));
        plan.push_back(req_row(FN_D3, 0));
        plan.push_back(known_row(FN_POINT, 65536, -32768, 32767, -1, 1'b0));
        // quadratic: third order is an error, end point is C
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd3));
        plan.push_back(known_row(FN_D3, 5, 0, 0, 0, 1'b1));
        plan.push_back(req_row(FN_D2, 77));
        plan.push_back(known_row(FN_POINT, 65536, 12345, -23456, -32768, 1'b0));
        // writes to unmapped indexes leave the points alone
        plan.push_back(cfg_row(REG_UNMAPPED_FIRST, '1));
        plan.push_back(cfg_row(REG_UNMAPPED_LAST, '1));
        plan.push_back(known_row(FN_POINT, 0, 32767, -32768, 1, 1'b0));
        plan.push_back(cfg_row(REG_POINT_COUNT, 48'd1));
        plan.push_back(known_row(FN_D1, 12345, -32768, 32768, 32766, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                if (in_busy) begin
                    drain_results();
                    in_busy = 1'b0;
                end
                write_reg(plan[r].reg_idx, plan[r].reg_data);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) begin
                    i_cfg_valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                send_request(plan[r].func, plan[r].t, plan[r].typed, plan[r].want);
                in_busy = 1'b1;
                n_directed++;
            end
        end

        // random phases: fresh count and points each time, one phase gapless
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_reg(REG_POINT_COUNT, PT_BITS'(phase_counts[p]));
            for (int q = 0; q < NUM_POINT_REGS; q++)
                write_reg(CFG_IDX_BITS'(REG_POINT_A + q),
                          {rand_coord(), rand_coord(), rand_coord()});
            if ($urandom_range(1))
                write_reg(CFG_IDX_BITS'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)),
                          PT_BITS'({$urandom(), $urandom()}));
            i_cfg_valid <= 1'b0;
            calm = (p == CALM_PHASE);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_request(FUNC_BITS'($urandom_range(3)), pick_t_param(), 1'b0, '0);
                // now and then hold off mid-phase until the pipe is empty
                if ($urandom_range(99) == 0) drain_results();
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("Run covered %0d requests (%0d directed) over %0d point-count settings",
                 n_requests, n_directed, n_settings);
        $display("%0d results checked, %0d of them order errors, %0d mismatches",
                 n_checked, n_order_err, n_mismatch);
        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
